// ===== sv/xcrr_pkg.sv =====
// Shared types and constants for the XOR-checked response receiver.
`default_nettype none

package xcrr_pkg;

   // Item function codes.
   localparam logic [1:0] FUNC_BYTE = 2'd0;
   localparam logic [1:0] FUNC_TICK = 2'd1;
   localparam logic [1:0] FUNC_ARM  = 2'd2;
   localparam logic [1:0] FUNC_NONE = 2'd3;

   // Result status codes.
   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_NUMBER   = 3'd1;
   localparam logic [2:0] ST_ERROR    = 3'd2;
   localparam logic [2:0] ST_UNKNOWN  = 3'd3;
   localparam logic [2:0] ST_CHECKSUM = 3'd4;
   localparam logic [2:0] ST_TIMEOUT  = 3'd5;
   localparam logic [2:0] ST_TOO_LONG = 3'd6;

   // Number parser phases.
   localparam logic [1:0] PH_SKIP   = 2'd0;
   localparam logic [1:0] PH_DIGITS = 2'd1;
   localparam logic [1:0] PH_DONE   = 2'd2;

   // Characters with a special meaning.
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_OK    = 8'h4F;
   localparam logic [7:0] CHAR_ERR   = 8'h45;
   localparam logic [7:0] CHAR_CMD   = 8'h43;

   // Configuration register indexes and reset values.
   localparam logic CSR_IDLE_TICK_LIMIT = 1'b0;
   localparam logic CSR_MAX_FRAME_BYTES = 1'b1;
   localparam logic [7:0] IDLE_TICK_LIMIT_RESET = 8'd10;
   localparam logic [7:0] MAX_FRAME_BYTES_RESET = 8'd20;

   typedef struct packed {
      logic [7:0] idle_tick_limit;
      logic [7:0] max_frame_bytes;
   } cfg_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] number;
   } result_type;

endpackage

`default_nettype wire

// ===== sv/xcrr_accum.sv =====
// Saturating decimal accumulate step: acc * 10 + digit, capped at 2^(VALUE_BITS-1).
`default_nettype none

module xcrr_accum #(
   parameter int VALUE_BITS = 32
) (
   input  wire logic [VALUE_BITS-1:0] acc,
   input  wire logic [3:0]            digit,
   output logic      [VALUE_BITS-1:0] acc_next
);

   localparam int WW = VALUE_BITS + 4;
   localparam logic [WW-1:0] CAP_W = {{(WW-1){1'b0}}, 1'b1} << (VALUE_BITS - 1);

   logic [WW-1:0] acc_w;
   logic [WW-1:0] prod;

   // acc > (cap - d) / 10 holds exactly when acc * 10 + d > cap.
   always_comb begin
      acc_w = {4'b0000, acc};
      prod  = (acc_w << 3) + (acc_w << 1) + {{(WW-4){1'b0}}, digit};
      if (prod > CAP_W) begin
         acc_next = CAP_W[VALUE_BITS-1:0];
      end else begin
         acc_next = prod[VALUE_BITS-1:0];
      end
   end

endmodule

`default_nettype wire

// ===== sv/xcrr_core.sv =====
// Frame state and per-item decode: checksum, lead byte, number parse, limits.
`default_nettype none

module xcrr_core #(
   parameter int VALUE_BITS = 32
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step_en,
   input  wire logic [1:0]           func,
   input  wire logic [7:0]           rx_byte,
   input  wire xcrr_pkg::cfg_type    cfg,
   output logic                      res_valid,
   output xcrr_pkg::result_type      res
);

   localparam int NW = (VALUE_BITS > 32) ? VALUE_BITS : 32;
   localparam logic [VALUE_BITS-1:0] CAP_M1 =
      ({{(VALUE_BITS-1){1'b0}}, 1'b1} << (VALUE_BITS - 1)) - {{(VALUE_BITS-1){1'b0}}, 1'b1};

   logic                  armed_ff, armed_in;
   logic [7:0]            count_ff, count_in;
   logic [7:0]            xor_ff, xor_in;
   logic [7:0]            held_ff, held_in;
   logic                  held_valid_ff, held_valid_in;
   logic [7:0]            lead_ff, lead_in;
   logic [1:0]            phase_ff, phase_in;
   logic                  neg_ff, neg_in;
   logic [VALUE_BITS-1:0] acc_ff, acc_in;
   logic [7:0]            idle_ff, idle_in;

   logic [VALUE_BITS-1:0] acc_step;
   logic                  is_digit;
   logic                  is_space;
   logic                  is_term;
   logic [8:0]            idle_next;
   logic [7:0]            count_next;
   logic [NW-1:0]         acc_ext;
   logic [NW-1:0]         neg_val;
   logic [VALUE_BITS-1:0] pos_val;
   logic [31:0]           final_number;

   xcrr_accum #(.VALUE_BITS(VALUE_BITS)) u_accum (
      .acc      (acc_ff),
      .digit    (held_ff[3:0]),
      .acc_next (acc_step)
   );

   always_comb begin
      is_digit = (held_ff >= xcrr_pkg::CHAR_ZERO) && (held_ff <= xcrr_pkg::CHAR_NINE);
      is_space = (held_ff == xcrr_pkg::CHAR_SPACE) ||
                 ((held_ff >= xcrr_pkg::CHAR_TAB) && (held_ff <= xcrr_pkg::CHAR_CR));
      is_term  = (rx_byte == xcrr_pkg::CHAR_CR) || (rx_byte == xcrr_pkg::CHAR_LF);
      idle_next  = {1'b0, idle_ff} + 9'd1;
      count_next = (count_ff == 8'hFF) ? count_ff : count_ff + 8'd1;

      // A negative magnitude wraps; a positive one clamps to the largest value.
      acc_ext = NW'(acc_ff);
      neg_val = '0 - acc_ext;
      pos_val = (acc_ff > CAP_M1) ? CAP_M1 : acc_ff;
      final_number = neg_ff ? neg_val[31:0] : 32'(NW'(pos_val));
   end

   always_comb begin
      armed_in      = armed_ff;
      count_in      = count_ff;
      xor_in        = xor_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      lead_in       = lead_ff;
      phase_in      = phase_ff;
      neg_in        = neg_ff;
      acc_in        = acc_ff;
      idle_in       = idle_ff;
      res_valid     = 1'b0;
      res.status    = xcrr_pkg::ST_OK;
      res.number    = '0;

      if (step_en) begin
         unique case (func)
            xcrr_pkg::FUNC_ARM: begin
               armed_in      = 1'b1;
               count_in      = '0;
               xor_in        = '0;
               held_in       = '0;
               held_valid_in = 1'b0;
               lead_in       = '0;
               phase_in      = xcrr_pkg::PH_SKIP;
               neg_in        = 1'b0;
               acc_in        = '0;
               idle_in       = '0;
            end
            xcrr_pkg::FUNC_TICK: begin
               if (armed_ff) begin
                  if (idle_next > {1'b0, cfg.idle_tick_limit}) begin
                     res_valid  = 1'b1;
                     res.status = xcrr_pkg::ST_TIMEOUT;
                     armed_in   = 1'b0;
                  end else begin
                     idle_in = idle_next[7:0];
                  end
               end
            end
            xcrr_pkg::FUNC_BYTE: begin
               if (armed_ff) begin
                  idle_in = '0;
                  if (is_term) begin
                     res_valid = 1'b1;
                     armed_in  = 1'b0;
                     priority if (!held_valid_ff || (held_ff != xor_ff)) begin
                        res.status = xcrr_pkg::ST_CHECKSUM;
                     end else if ((count_ff >= 8'd2) && (lead_ff == xcrr_pkg::CHAR_OK)) begin
                        res.status = xcrr_pkg::ST_OK;
                     end else if ((count_ff >= 8'd2) && (lead_ff == xcrr_pkg::CHAR_ERR)) begin
                        res.status = xcrr_pkg::ST_ERROR;
                     end else if ((count_ff >= 8'd2) && (lead_ff == xcrr_pkg::CHAR_CMD)) begin
                        res.status = xcrr_pkg::ST_UNKNOWN;
                     end else begin
                        res.status = xcrr_pkg::ST_NUMBER;
                        res.number = final_number;
                     end
                  end else begin
                     // The held byte turns out to be payload, not the checksum.
                     if (held_valid_ff) begin
                        if (count_ff == 8'd1) begin
                           lead_in = held_ff;
                        end
                        xor_in = xor_ff ^ held_ff;
                        case (phase_ff)
                           xcrr_pkg::PH_SKIP: begin
                              priority if (is_space) begin
                                 phase_in = xcrr_pkg::PH_SKIP;
                              end else if (held_ff == xcrr_pkg::CHAR_PLUS) begin
                                 phase_in = xcrr_pkg::PH_DIGITS;
                              end else if (held_ff == xcrr_pkg::CHAR_MINUS) begin
                                 neg_in   = 1'b1;
                                 phase_in = xcrr_pkg::PH_DIGITS;
                              end else if (is_digit) begin
                                 acc_in   = acc_step;
                                 phase_in = xcrr_pkg::PH_DIGITS;
                              end else begin
                                 phase_in = xcrr_pkg::PH_DONE;
                              end
                           end
                           xcrr_pkg::PH_DIGITS: begin
                              if (is_digit) begin
                                 acc_in = acc_step;
                              end else begin
                                 phase_in = xcrr_pkg::PH_DONE;
                              end
                           end
                           default: begin
                              phase_in = phase_ff;
                           end
                        endcase
                     end
                     held_in       = rx_byte;
                     held_valid_in = 1'b1;
                     count_in      = count_next;
                     if (count_next >= cfg.max_frame_bytes) begin
                        res_valid  = 1'b1;
                        res.status = xcrr_pkg::ST_TOO_LONG;
                        armed_in   = 1'b0;
                     end
                  end
               end
            end
            default: begin
               armed_in = armed_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff      <= 1'b0;
         count_ff      <= '0;
         xor_ff        <= '0;
         held_ff       <= '0;
         held_valid_ff <= 1'b0;
         lead_ff       <= '0;
         phase_ff      <= xcrr_pkg::PH_SKIP;
         neg_ff        <= 1'b0;
         acc_ff        <= '0;
         idle_ff       <= '0;
      end else begin
         armed_ff      <= armed_in;
         count_ff      <= count_in;
         xor_ff        <= xor_in;
         held_ff       <= held_in;
         held_valid_ff <= held_valid_in;
         lead_ff       <= lead_in;
         phase_ff      <= phase_in;
         neg_ff        <= neg_in;
         acc_ff        <= acc_in;
         idle_ff       <= idle_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/xor_checked_response_receiver.sv =====
// XOR-checked response receiver: takes reply bytes and poll ticks, reports one status per frame.
//
// Usage: the req_ channel carries one item per accepted cycle: req_func selects
// a received byte (req_rx_byte), a poll tick, or arm-and-clear. Once armed, the
// block collects bytes until CR or LF, checks the XOR checksum in the byte
// before the terminator, and returns one rsp_ item (rsp_status, rsp_number).
// Timeouts and over-long frames are reported as soon as they occur. Any
// reported result disarms the block until the next arm item.
// An accepted item is registered in the input register, then decoded into the
// result register once the output is free, and offered on rsp_ from there.
// Throughput is one item per cycle while no result is stalled; the frame
// state update between the input and result registers sets that figure.
// Reset clears the input and result registers, disarms the block and sets the
// csr_ registers to their defaults (idle tick limit 10, frame limit 20).
// When the receiver holds rsp_stall, the waiting result stays on rsp_ and the
// input register keeps one more item; after that req_stall is raised.
// The csr_ port should only be written while no item is in flight.
`default_nettype none

module xor_checked_response_receiver #(
   parameter int VALUE_BITS = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_func,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [2:0]       rsp_status,
   output logic [31:0]      rsp_number,
   input  wire logic        csr_write,
   input  wire logic        csr_index,
   input  wire logic [7:0]  csr_wdata
);

   xcrr_pkg::cfg_type    cfg_ff, cfg_in;
   logic                 in_valid_ff, in_valid_in;
   logic [1:0]           in_func_ff, in_func_in;
   logic [7:0]           in_byte_ff, in_byte_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   xcrr_pkg::result_type rsp_data_ff, rsp_data_in;

   logic                 out_free;
   logic                 advance;
   logic                 res_valid;
   xcrr_pkg::result_type res;

   xcrr_core #(.VALUE_BITS(VALUE_BITS)) u_core (
      .clock     (clock),
      .reset     (reset),
      .step_en   (advance),
      .func      (in_func_ff),
      .rx_byte   (in_byte_ff),
      .cfg       (cfg_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   always_comb begin
      out_free  = !rsp_valid_ff || !rsp_stall;
      advance   = in_valid_ff && out_free;
      req_stall = in_valid_ff && !out_free;

      in_valid_in = in_valid_ff && !advance;
      in_func_in  = in_func_ff;
      in_byte_in  = in_byte_ff;
      if (req_valid && !req_stall) begin
         in_valid_in = 1'b1;
         in_func_in  = req_func;
         in_byte_in  = req_rx_byte;
      end

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         rsp_valid_in = res_valid;
         rsp_data_in  = res;
      end

      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            xcrr_pkg::CSR_IDLE_TICK_LIMIT: cfg_in.idle_tick_limit = csr_wdata;
            xcrr_pkg::CSR_MAX_FRAME_BYTES: cfg_in.max_frame_bytes = csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff            <= 1'b0;
         rsp_valid_ff           <= 1'b0;
         cfg_ff.idle_tick_limit <= xcrr_pkg::IDLE_TICK_LIMIT_RESET;
         cfg_ff.max_frame_bytes <= xcrr_pkg::MAX_FRAME_BYTES_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      in_func_ff  <= in_func_in;
      in_byte_ff  <= in_byte_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_data_ff.status;
   assign rsp_number = rsp_data_ff.number;

   // A number is only carried by a number result.
   a_number_only_for_number: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff.status != xcrr_pkg::ST_NUMBER) |-> rsp_data_ff.number == '0)
      else $error("nonzero number on a non-number result");

   // An item that could not be decoded stays in the input register unchanged.
   a_input_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_func_ff) && $stable(in_byte_ff))
      else $error("pending item lost from the input register");

   // A stalled result is never overwritten by a newly decoded item.
   a_no_decode_over_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |-> !advance)
      else $error("item decoded while a result was stalled");

endmodule

`default_nettype wire

// ===== tb/sv/xcrr_reply_checker.sv =====
// Reply checker for the XOR-checked response receiver: predicts each reply and compares it.
`default_nettype none

module xcrr_reply_checker #(
   parameter int VALUE_BITS = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic [1:0]  req_func,
   input  wire logic [7:0]  req_rx_byte,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic [2:0]  rsp_status,
   input  wire logic [31:0] rsp_number,
   input  wire logic        csr_write,
   input  wire logic        csr_index,
   input  wire logic [7:0]  csr_wdata,
   output logic [31:0]      mismatch_total,
   output logic [31:0]      replies_owed
);
   import xcrr_pkg::*;

   localparam logic [63:0] MAG_CAP = 64'd1 << (VALUE_BITS - 1);

   logic [7:0]  tick_limit;
   logic [7:0]  frame_limit;
   logic        frame_armed;
   logic [7:0]  byte_total;
   logic [7:0]  xor_sum;
   logic [7:0]  held_char;
   logic        held_ok;
   logic [7:0]  first_char;
   logic [1:0]  parse_phase;
   logic        minus_seen;
   logic [63:0] magnitude;
   logic [7:0]  idle_count;
   result_type  reply_queue[$];

   task automatic report(input string what);
      $display("reply mismatch at %0t: %s", $time, what);
      mismatch_total++;
   endtask

   task automatic clear_frame();
      byte_total = '0;
      xor_sum = '0;
      held_char = '0;
      held_ok = 1'b0;
      first_char = '0;
      parse_phase = PH_SKIP;
      minus_seen = 1'b0;
      magnitude = '0;
      idle_count = '0;
   endtask

   // Digits past the signed range pin the magnitude at the cap.
   function automatic logic [63:0] append_digit(input logic [63:0] m, input logic [7:0] ch);
      logic [63:0] d;
      d = 64'(ch - CHAR_ZERO);
      return (m > (MAG_CAP - d) / 10) ? MAG_CAP : m * 10 + d;
   endfunction

   task automatic predict_reply(input logic [1:0] f, input logic [7:0] c);
      result_type r;
      logic       done;
      logic [8:0] next_idle;
      logic       is_digit;
      logic       is_blank;
      r = '0;
      done = 1'b0;
      next_idle = {1'b0, idle_count} + 9'd1;
      if (f == FUNC_ARM) begin
         clear_frame();
         frame_armed = 1'b1;
      end else if (frame_armed && f == FUNC_TICK) begin
         if (next_idle > {1'b0, tick_limit}) begin
            r.status = ST_TIMEOUT;
            done = 1'b1;
         end else begin
            idle_count = next_idle[7:0];
         end
      end else if (frame_armed && f == FUNC_BYTE) begin
         idle_count = '0;
         if (c == CHAR_CR || c == CHAR_LF) begin
            done = 1'b1;
            if (!held_ok || held_char != xor_sum) begin
               r.status = ST_CHECKSUM;
            end else if (byte_total >= 8'd2 && first_char == CHAR_OK) begin
               r.status = ST_OK;
            end else if (byte_total >= 8'd2 && first_char == CHAR_ERR) begin
               r.status = ST_ERROR;
            end else if (byte_total >= 8'd2 && first_char == CHAR_CMD) begin
               r.status = ST_UNKNOWN;
            end else begin
               r.status = ST_NUMBER;
               if (minus_seen) r.number = 32'(64'd0 - magnitude);
               else if (magnitude > MAG_CAP - 1) r.number = 32'(MAG_CAP - 1);
               else r.number = magnitude[31:0];
            end
         end else begin
            if (held_ok) begin
               // A new byte proves the held one was payload, not the checksum.
               is_digit = held_char >= CHAR_ZERO && held_char <= CHAR_NINE;
               is_blank = held_char == CHAR_SPACE ||
                          (held_char >= CHAR_TAB && held_char <= CHAR_CR);
               if (byte_total == 8'd1) first_char = held_char;
               xor_sum ^= held_char;
               if (parse_phase == PH_SKIP) begin
                  if (held_char == CHAR_PLUS) begin
                     parse_phase = PH_DIGITS;
                  end else if (held_char == CHAR_MINUS) begin
                     minus_seen = 1'b1;
                     parse_phase = PH_DIGITS;
                  end else if (is_digit) begin
                     magnitude = append_digit(magnitude, held_char);
                     parse_phase = PH_DIGITS;
                  end else if (!is_blank) begin
                     parse_phase = PH_DONE;
                  end
               end else if (parse_phase == PH_DIGITS) begin
                  if (is_digit) magnitude = append_digit(magnitude, held_char);
                  else parse_phase = PH_DONE;
               end
            end
            held_char = c;
            held_ok = 1'b1;
            if (byte_total != 8'hFF) byte_total++;
            if (byte_total >= frame_limit) begin
               r.status = ST_TOO_LONG;
               done = 1'b1;
            end
         end
      end
      if (done) begin
         frame_armed = 1'b0;
         reply_queue.push_back(r);
      end
   endtask

   task automatic compare_reply();
      result_type want;
      if (reply_queue.size() == 0) begin
         report($sformatf("unexpected reply, status %0d number %0d",
                          rsp_status, $signed(rsp_number)));
      end else begin
         want = reply_queue.pop_front();
         if (rsp_status != want.status)
            report($sformatf("status %0d, predicted %0d", rsp_status, want.status));
         if (rsp_number != want.number)
            report($sformatf("number %0d, predicted %0d",
                             $signed(rsp_number), $signed(want.number)));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         mismatch_total = '0;
         tick_limit = IDLE_TICK_LIMIT_RESET;
         frame_limit = MAX_FRAME_BYTES_RESET;
         frame_armed = 1'b0;
         clear_frame();
         reply_queue.delete();
      end else begin
         if (rsp_valid && !rsp_stall) compare_reply();
         if (req_valid && !req_stall) predict_reply(req_func, req_rx_byte);
         if (csr_write) begin
            if (csr_index == CSR_IDLE_TICK_LIMIT) tick_limit = csr_wdata;
            else frame_limit = csr_wdata;
         end
      end
      replies_owed <= reply_queue.size();
   end

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Testbench top: drives reply frames, ticks and limit settings into the receiver and gives the verdict.
`default_nettype none

module tb_top;
   import xcrr_pkg::*;

   localparam int WATCHDOG_LIMIT = 1500;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_func = FUNC_NONE;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_number;
   logic        csr_write = 1'b0;
   logic        csr_index = CSR_IDLE_TICK_LIMIT;
   logic [7:0]  csr_wdata = 8'h00;
   logic [31:0] mismatch_total;
   logic [31:0] replies_owed;

   logic        calm = 1'b0;
   logic        hold_req = 1'b0;
   int          items_sent = 0;
   int          idle_cycles = 0;
   logic [7:0]  cur_tick_limit = IDLE_TICK_LIMIT_RESET;
   logic [7:0]  cur_frame_limit = MAX_FRAME_BYTES_RESET;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   xor_checked_response_receiver uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_func(req_func), .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_status(rsp_status), .rsp_number(rsp_number),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   xcrr_reply_checker reply_check (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_func(req_func), .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_status(rsp_status), .rsp_number(rsp_number),
      .csr_write(csr_write), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .mismatch_total(mismatch_total), .replies_owed(replies_owed)
   );

   // Back to back when calm; otherwise mostly back to back, sometimes a short gap, now and then a long pause.
   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [7:0] data_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255)); while (b == CHAR_CR || b == CHAR_LF);
      return b;
   endfunction

   task automatic put_item(input logic [1:0] f, input logic [7:0] b);
      int   gap;
      logic go;
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= f;
      req_rx_byte <= b;
      do begin
         @(negedge clock);
         go = !req_stall;
         @(posedge clock);
      end while (!go);
      items_sent++;
   endtask

   // Drop valid, let every predicted reply drain, then give the pipeline time to empty.
   task automatic settle();
      req_valid <= 1'b0;
      @(negedge clock);
      while (replies_owed != 0) @(negedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic set_limits(input logic [7:0] idle_lim, input logic [7:0] frame_lim);
      csr_write <= 1'b1;
      csr_index <= CSR_IDLE_TICK_LIMIT;
      csr_wdata <= idle_lim;
      @(posedge clock);
      csr_index <= CSR_MAX_FRAME_BYTES;
      csr_wdata <= frame_lim;
      @(posedge clock);
      csr_write <= 1'b0;
      cur_tick_limit = idle_lim;
      cur_frame_limit = frame_lim;
   endtask

   task automatic random_frame();
      logic [7:0]       body[$];
      logic [7:0]       sum;
      int               kind;
      int               room;
      int               tick_cap;
      string            digits;
      longint unsigned  v;
      kind = $urandom_range(0, 9);
      case (kind)
         0, 1, 2: begin
            body.push_back(kind == 0 ? CHAR_OK : (kind == 1 ? CHAR_ERR : CHAR_CMD));
            repeat ($urandom_range(0, 3)) body.push_back(data_byte());
         end
         3, 4, 5, 6: begin
            repeat ($urandom_range(0, 2)) begin
               // Vertical tab and form feed count as blanks as well.
               case ($urandom_range(0, 3))
                  0: body.push_back(CHAR_SPACE);
                  1: body.push_back(CHAR_TAB);
                  2: body.push_back(8'h0B);
                  default: body.push_back(8'h0C);
               endcase
            end
            case ($urandom_range(0, 3))
               0: body.push_back(CHAR_PLUS);
               1: body.push_back(CHAR_MINUS);
               default: ;
            endcase
            case ($urandom_range(0, 5))
               0: v = 64'd2147483647;
               1: v = 64'd2147483648;
               2: v = {$urandom, $urandom};
               3: v = $urandom;
               default: v = $urandom_range(0, 999);
            endcase
            digits = $sformatf("%0d", v);
            for (int i = 0; i < digits.len(); i++) body.push_back(digits[i]);
            if ($urandom_range(0, 3) == 0) body.push_back(data_byte());
         end
         default: repeat ($urandom_range(0, 6)) body.push_back(data_byte());
      endcase

      // Most frames are trimmed to fit under the frame limit; the rest may run over it.
      room = int'(cur_frame_limit) - 2;
      if ($urandom_range(0, 4) != 0)
         while (body.size() > room && body.size() > 0) void'(body.pop_back());

      sum = '0;
      foreach (body[i]) sum ^= body[i];
      if ($urandom_range(0, 9) == 0) sum ^= 8'($urandom_range(1, 255));
      body.push_back(sum);

      tick_cap = (cur_tick_limit == 0) ? 1 : (cur_tick_limit > 4 ? 4 : cur_tick_limit);
      if ($urandom_range(0, 19) != 0) put_item(FUNC_ARM, 8'($urandom));
      foreach (body[i]) begin
         if ($urandom_range(0, 5) == 0)
            repeat ($urandom_range(1, tick_cap)) put_item(FUNC_TICK, 8'($urandom));
         if ($urandom_range(0, 29) == 0) put_item(FUNC_NONE, 8'($urandom));
         put_item(FUNC_BYTE, body[i]);
      end
      case ($urandom_range(0, 19))
         0: ;
         1: if (cur_tick_limit < 40)
               repeat (int'(cur_tick_limit) + 1) put_item(FUNC_TICK, 8'($urandom));
         default: put_item(FUNC_BYTE, $urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
      endcase
      if ($urandom_range(0, 4) == 0)
         put_item(2'($urandom_range(0, 3)) == FUNC_ARM ? FUNC_NONE : 2'($urandom_range(0, 3)),
                  8'($urandom));
   endtask

   task automatic random_phase(input int budget);
      int start;
      start = items_sent;
      while (items_sent - start < budget) begin
         calm = ($urandom_range(0, 4) == 0);
         random_frame();
      end
      calm = 1'b0;
      settle();
   endtask

   initial begin : stimulus
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      set_limits(8'd0, 8'd4);

      // Items while disarmed and the unused function code change nothing.
      put_item(FUNC_TICK, 8'h00);
      put_item(FUNC_BYTE, CHAR_OK);
      put_item(FUNC_NONE, 8'hFF);
      put_item(FUNC_ARM, 8'h00);
      put_item(FUNC_BYTE, CHAR_OK);
      put_item(FUNC_BYTE, CHAR_OK);
      put_item(FUNC_BYTE, CHAR_CR);
      // A terminator with nothing before it is a checksum failure.
      put_item(FUNC_ARM, 8'h00);
      put_item(FUNC_BYTE, CHAR_CR);
      // A NUL checksum alone is an empty payload worth zero.
      put_item(FUNC_ARM, 8'h00);
      put_item(FUNC_BYTE, 8'h00);
      put_item(FUNC_BYTE, CHAR_LF);
      // With no idle ticks allowed, the first tick times out.
      put_item(FUNC_ARM, 8'h00);
      put_item(FUNC_TICK, 8'hFF);
      put_item(FUNC_ARM, 8'h00);
      put_item(FUNC_BYTE, CHAR_MINUS);
      put_item(FUNC_BYTE, CHAR_NINE);
      put_item(FUNC_BYTE, CHAR_MINUS ^ CHAR_NINE);
      put_item(FUNC_BYTE, CHAR_CR);
      // Fourth byte without a terminator hits the frame limit.
      put_item(FUNC_ARM, 8'h00);
      put_item(FUNC_BYTE, 8'hFF);
      put_item(FUNC_BYTE, 8'h00);
      put_item(FUNC_BYTE, 8'h80);
      put_item(FUNC_BYTE, 8'h7F);
      put_item(FUNC_ARM, 8'h00);
      put_item(FUNC_NONE, 8'h00);
      settle();

      set_limits(IDLE_TICK_LIMIT_RESET, MAX_FRAME_BYTES_RESET);
      hold_req = 1'b1;
      random_phase(140);
      set_limits(8'd0, 8'd3);
      random_phase(100);
      set_limits(8'd255, 8'd255);
      random_phase(120);
      set_limits(8'd2, 8'd12);
      random_phase(140);
      set_limits(8'($urandom_range(1, 40)), 8'($urandom_range(6, 60)));
      random_phase(150);

      if (mismatch_total == 0 && replies_owed == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

   initial begin : reply_side
      int held;
      int backoff;
      bit hold_used;
      held = 0;
      backoff = 0;
      hold_used = 1'b0;
      forever begin
         @(posedge clock);
         // One long hold-off lets the receiver fill up and push back on its input.
         if (hold_req && !hold_used) begin
            hold_used = 1'b1;
            held = 120;
         end
         if (held > 0) begin
            rsp_stall <= 1'b1;
            held--;
         end else if (backoff > 0) begin
            rsp_stall <= 1'b1;
            backoff--;
         end else begin
            rsp_stall <= 1'b0;
            if (!calm && $urandom_range(0, 3) == 0) backoff = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

endmodule

`default_nettype wire

// ===== xor_checked_response_receiver.f =====
sv/xcrr_pkg.sv
sv/xcrr_accum.sv
sv/xcrr_core.sv
sv/xor_checked_response_receiver.sv
tb/sv/xcrr_reply_checker.sv
tb/sv/tb_top.sv
